>>> rtl/core/pds_pkg.sv
package pds_pkg;

    // Field and register widths
    localparam int FREQ_W     = 30;
    localparam int VCXO_W     = 30;
    localparam int PFD_W      = 27;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 30;
    localparam int DIV_R_W    = 14;
    localparam int DIV_N_W    = 13;
    localparam int CP_W       = 4;
    localparam int LOCK_W     = 14;

    // Search limits
    localparam int DEF_MAX_REF_DIV = 16363;
    localparam int DEF_MAX_FB_DIV  = 8191;
    localparam int MAX_LOCK_COUNT  = 16363;

    // Configuration reset values
    localparam logic [VCXO_W-1:0] VCXO_RESET    = VCXO_W'(122880000);
    localparam logic [PFD_W-1:0]  PFD_MAX_RESET = PFD_W'(1200000);
    localparam logic [PFD_W-1:0]  PFD_MIN_RESET = PFD_W'(80000);

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VCXO    = 2'd0,
        CFG_PFD_MAX = 2'd1,
        CFG_PFD_MIN = 2'd2
    } cfg_idx_t;

    // Charge pump: min(n / 50, 15), n / 50 by reciprocal 1311 / 2^16 for n < 800
    localparam int CP_DIV    = 50;
    localparam int CP_MAX    = 15;
    localparam int CP_SAT_N  = CP_DIV * (CP_MAX + 1);
    localparam int CP_N_W    = 10;
    localparam int CP_RECIP  = 1311;
    localparam int CP_RCP_W  = 11;
    localparam int CP_SHIFT  = 16;

    // Lock detect: (2f + 125r) / (250r)
    localparam int LOCK_HALF_K = 125;
    localparam int LOCK_DEN_K  = 250;
    localparam int LOCK_NUM_W  = FREQ_W + 2;

    // Shared divider unit
    localparam int DIV_NW = VCXO_W + 15;   // dividend shift register
    localparam int DIV_DW = 30;            // divisor and remainder
    localparam int DIV_QW = 32;            // quotient
    localparam int DIV_CW = 6;             // step count

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] divisor;
        logic [DIV_DW-1:0] rem_init;
        logic [DIV_NW-1:0] bits;
        logic [DIV_CW-1:0] count;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_QW-1:0] quo;
        logic [DIV_DW-1:0] rem;
    } div_rsp_t;

endpackage

>>> rtl/core/pds_if.sv
interface pds_in_if;
    import pds_pkg::*;

    logic              valid;
    logic              ready;
    logic [FREQ_W-1:0] ref_freq_hz;

    modport source (output valid, output ref_freq_hz, input ready);
    modport sink   (input valid, input ref_freq_hz, output ready);
endinterface

interface pds_out_if;
    import pds_pkg::*;

    logic               valid;
    logic               ready;
    logic               found;
    logic [DIV_R_W-1:0] div_r;
    logic [DIV_N_W-1:0] div_n;
    logic [CP_W-1:0]    charge_pump;
    logic [LOCK_W-1:0]  lock_detect_count;

    modport source (output valid, output found, output div_r, output div_n,
                    output charge_pump, output lock_detect_count, input ready);
    modport sink   (input valid, input found, input div_r, input div_n,
                    input charge_pump, input lock_detect_count, output ready);
endinterface

>>> rtl/core/pds_divider.sv
module pds_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  pds_pkg::div_req_t req,
    output pds_pkg::div_rsp_t rsp
);
    import pds_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] dvs_reg;
    logic [DIV_NW-1:0] bits_reg;
    logic [DIV_QW-1:0] quo_reg;

    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   diff;
    logic              take;
    logic [DIV_DW-1:0] rem_next;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial    = {rem_reg, bits_reg[DIV_NW-1]};
        diff     = trial - {1'b0, dvs_reg};
        take     = (trial >= {1'b0, dvs_reg});
        rem_next = take ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= req.count;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == DIV_CW'(1));
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DIV_CW'(1);
                if (cnt_reg == DIV_CW'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= req.rem_init;
            dvs_reg  <= req.divisor;
            bits_reg <= req.bits;
            quo_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            bits_reg <= {bits_reg[DIV_NW-2:0], 1'b0};
            quo_reg  <= {quo_reg[DIV_QW-2:0], take};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

>>> rtl/core/pll_divider_search.sv
// PLL divider search. Each transaction on freq carries a reference frequency in
// hertz; the block answers with one transaction on dividers holding the first
// reference divider R (starting at ref / pfd_max, at least 1) for which
// vcxo * R / ref is an exact integer N, together with the charge pump code
// min(N / 50, 15) and the lock detect count round(ref / (125 R)), or found = 0
// with all fields zero. One item is in flight at a time; freq.ready is low
// from acceptance until the result has been taken. All divisions run on one
// shared restoring divider at one quotient bit per cycle: the start divider,
// each candidate R (QW quotient bits, QW = bits of MAX_FB_DIV, 13 by default)
// and the lock count, with at most MAX_REF_DIV candidates. Configuration
// registers are written through cfg_we / cfg_index / cfg_data; the user must
// write them only while no item is in flight, which the block itself does
// not enforce.
module pll_divider_search #(
    parameter int MAX_REF_DIV = pds_pkg::DEF_MAX_REF_DIV,
    parameter int MAX_FB_DIV  = pds_pkg::DEF_MAX_FB_DIV
) (
    input  logic                             clk,
    input  logic                             rst_n,
    pds_in_if.sink                           freq,
    pds_out_if.source                        dividers,
    input  logic                             cfg_we,
    input  logic [pds_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pds_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pds_pkg::*;

    localparam int RW     = $clog2(MAX_REF_DIV + 2);       // R, can reach MAX + 1
    localparam int QW     = $clog2(MAX_FB_DIV + 1);        // N
    localparam int PW     = VCXO_W + RW;                   // vcxo * R
    localparam int FBL_W  = FREQ_W + $clog2(MAX_FB_DIV + 2);
    localparam int PMIN_W = PFD_W + RW;
    localparam int CMP_W  = (PW > FBL_W) ? PW : FBL_W;
    localparam int DEN_W  = 8 + RW;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_START  = 9'b000000010,
        ST_WAIT_R = 9'b000000100,
        ST_MUL    = 9'b000001000,
        ST_CHECK  = 9'b000010000,
        ST_WAIT_N = 9'b000100000,
        ST_FIN    = 9'b001000000,
        ST_WAIT_L = 9'b010000000,
        ST_OUT    = 9'b100000000
    } state_t;

    state_t state_reg;

    logic [VCXO_W-1:0] vcxo_reg;
    logic [PFD_W-1:0]  pfd_max_reg;
    logic [PFD_W-1:0]  pfd_min_reg;

    logic [FREQ_W-1:0]     f_reg;
    logic [RW-1:0]         r_reg;
    logic [QW-1:0]         n_reg;
    logic [PW-1:0]         prod_reg;
    logic [PMIN_W-1:0]     pmin_reg;
    logic [FBL_W-1:0]      fb_lim_reg;
    logic [DEN_W-1:0]      den_reg;
    logic [LOCK_NUM_W-1:0] num_reg;

    logic               found_reg;
    logic [DIV_R_W-1:0] div_r_reg;
    logic [DIV_N_W-1:0] div_n_reg;
    logic [CP_W-1:0]    cp_reg;
    logic [LOCK_W-1:0]  lock_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic                       zero_in;
    logic                       start_over;
    logic                       r_over;
    logic                       pfd_low;
    logic                       fb_over;
    logic                       exact;
    logic [DIV_NW-1:0]          prod_ext;
    logic [15:0]                n_wide;
    logic [CP_N_W+CP_RCP_W-1:0] cp_prod;
    logic [CP_W-1:0]            cp_next;
    logic [LOCK_W-1:0]          lock_next;

    pds_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcxo_reg    <= VCXO_RESET;
            pfd_max_reg <= PFD_MAX_RESET;
            pfd_min_reg <= PFD_MIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_VCXO:    vcxo_reg    <= cfg_data[VCXO_W-1:0];
                CFG_PFD_MAX: pfd_max_reg <= cfg_data[PFD_W-1:0];
                CFG_PFD_MIN: pfd_min_reg <= cfg_data[PFD_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        zero_in    = (f_reg == '0) || (pfd_max_reg == '0);
        start_over = (div_rsp.quo > DIV_QW'(MAX_REF_DIV));
        r_over     = (r_reg > RW'(MAX_REF_DIV));
        pfd_low    = (PMIN_W'(f_reg) < pmin_reg);
        // N > MAX_FB_DIV  <=>  vcxo * R >= (MAX_FB_DIV + 1) * f
        fb_over    = (CMP_W'(prod_reg) >= CMP_W'(fb_lim_reg));
        exact      = (div_rsp.rem == '0);
        prod_ext   = DIV_NW'(prod_reg);

        n_wide  = 16'(n_reg);
        cp_prod = n_wide[CP_N_W-1:0] * CP_RCP_W'(CP_RECIP);
        if (n_wide >= 16'(CP_SAT_N))
            cp_next = CP_W'(CP_MAX);
        else
            cp_next = cp_prod[CP_SHIFT+CP_W-1:CP_SHIFT];

        if (div_rsp.quo > DIV_QW'(MAX_LOCK_COUNT))
            lock_next = LOCK_W'(MAX_LOCK_COUNT);
        else
            lock_next = div_rsp.quo[LOCK_W-1:0];
    end

    // divider requests; inputs all come from registers
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.divisor  = DIV_DW'(f_reg);
        div_req.rem_init = '0;
        div_req.bits     = '0;
        div_req.count    = '0;
        case (state_reg)
            ST_START:
            begin
                // R0 = f / pfd_max
                div_req.start   = !zero_in;
                div_req.divisor = DIV_DW'(pfd_max_reg);
                div_req.bits    = {f_reg, (DIV_NW - FREQ_W)'(0)};
                div_req.count   = DIV_CW'(FREQ_W);
            end
            ST_CHECK:
            begin
                // quotient known to fit in QW bits, so only QW steps
                div_req.start    = !(pfd_low || fb_over);
                div_req.divisor  = DIV_DW'(f_reg);
                div_req.rem_init = prod_ext[QW +: DIV_DW];
                div_req.bits     = prod_ext << (DIV_NW - QW);
                div_req.count    = DIV_CW'(QW);
            end
            ST_FIN:
            begin
                div_req.start   = 1'b1;
                div_req.divisor = DIV_DW'(den_reg);
                div_req.bits    = {num_reg, (DIV_NW - LOCK_NUM_W)'(0)};
                div_req.count   = DIV_CW'(LOCK_NUM_W);
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                    if (freq.valid)
                        state_reg <= ST_START;
                ST_START:
                    state_reg <= zero_in ? ST_OUT : ST_WAIT_R;
                ST_WAIT_R:
                    if (div_rsp.done)
                        state_reg <= start_over ? ST_OUT : ST_MUL;
                ST_MUL:
                    state_reg <= r_over ? ST_OUT : ST_CHECK;
                ST_CHECK:
                    state_reg <= (pfd_low || fb_over) ? ST_OUT : ST_WAIT_N;
                ST_WAIT_N:
                    if (div_rsp.done)
                        state_reg <= exact ? ST_FIN : ST_MUL;
                ST_FIN:
                    state_reg <= ST_WAIT_L;
                ST_WAIT_L:
                    if (div_rsp.done)
                        state_reg <= ST_OUT;
                ST_OUT:
                    if (dividers.ready)
                        state_reg <= ST_IDLE;
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (freq.valid)
                    f_reg <= freq.ref_freq_hz;
            ST_START:
            begin
                fb_lim_reg <= FBL_W'(f_reg) * FBL_W'(MAX_FB_DIV + 1);
                found_reg  <= 1'b0;
                div_r_reg  <= '0;
                div_n_reg  <= '0;
                cp_reg     <= '0;
                lock_reg   <= '0;
            end
            ST_WAIT_R:
                if (div_rsp.done)
                    r_reg <= (div_rsp.quo == '0) ? RW'(1) : div_rsp.quo[RW-1:0];
            ST_MUL:
            begin
                prod_reg <= PW'(vcxo_reg) * PW'(r_reg);
                pmin_reg <= PMIN_W'(pfd_min_reg) * PMIN_W'(r_reg);
            end
            ST_WAIT_N:
                if (div_rsp.done)
                begin
                    if (exact)
                    begin
                        n_reg   <= div_rsp.quo[QW-1:0];
                        den_reg <= DEN_W'(r_reg) * DEN_W'(LOCK_DEN_K);
                        num_reg <= LOCK_NUM_W'({f_reg, 1'b0})
                                   + LOCK_NUM_W'(r_reg) * LOCK_NUM_W'(LOCK_HALF_K);
                    end
                    else
                    begin
                        r_reg <= r_reg + RW'(1);
                    end
                end
            ST_WAIT_L:
                if (div_rsp.done)
                begin
                    found_reg <= 1'b1;
                    div_r_reg <= DIV_R_W'(r_reg);
                    div_n_reg <= DIV_N_W'(n_reg);
                    cp_reg    <= cp_next;
                    lock_reg  <= lock_next;
                end
            default: ;
        endcase
    end

    assign freq.ready                 = (state_reg == ST_IDLE);
    assign dividers.valid             = (state_reg == ST_OUT);
    assign dividers.found             = found_reg;
    assign dividers.div_r             = div_r_reg;
    assign dividers.div_n             = div_n_reg;
    assign dividers.charge_pump       = cp_reg;
    assign dividers.lock_detect_count = lock_reg;

endmodule

>>> rtl/core/pds_checker.sv
module pds_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        freq_valid,
    input logic                        freq_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        found,
    input logic [pds_pkg::DIV_R_W-1:0] div_r,
    input logic [pds_pkg::DIV_N_W-1:0] div_n,
    input logic [pds_pkg::CP_W-1:0]    charge_pump,
    input logic [pds_pkg::LOCK_W-1:0]  lock_detect_count
);
    import pds_pkg::*;

    // one item at a time: never taking input while a result is shown
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        !(freq_ready && out_valid))
        else $error("input ready while result pending");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        freq_valid && freq_ready |=> !freq_ready)
        else $error("still ready after transaction accepted");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> div_r == '0 && div_n == '0
                                && charge_pump == '0 && lock_detect_count == '0)
        else $error("not-found result with nonzero fields");

    a_found_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> div_r != '0
                               && (div_n < DIV_N_W'(CP_DIV * CP_MAX) || charge_pump == CP_W'(CP_MAX))
                               && (div_n >= DIV_N_W'(CP_DIV) || charge_pump == '0))
        else $error("found result inconsistent");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(div_r) && $stable(div_n))
        else $error("stalled result changed");

endmodule

bind pll_divider_search pds_checker u_pds_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .freq_valid        (freq.valid),
    .freq_ready        (freq.ready),
    .out_valid         (dividers.valid),
    .out_ready         (dividers.ready),
    .found             (dividers.found),
    .div_r             (dividers.div_r),
    .div_n             (dividers.div_n),
    .charge_pump       (dividers.charge_pump),
    .lock_detect_count (dividers.lock_detect_count)
);
